// ----- rtl/annexb_to_length_prefixed_nal_top_macros.svh -----
// Assertion macros shared by the converter's RTL.
`ifndef ANNEXB_TO_LENGTH_PREFIXED_NAL_TOP_MACROS_SVH
`define ANNEXB_TO_LENGTH_PREFIXED_NAL_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define A2L_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define A2L_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/a2l_pkg.sv -----
package a2l_pkg;

    localparam int unsigned A2L_OUT_ADDR_BITS = 16;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_DONE    = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] write_addr;
        logic [7:0]  write_data;
        logic [16:0] total_size;
        logic        overflow;
        logic        last_of_run;
    } t_out_item;

endpackage

// ----- rtl/a2l_chan_if.sv -----
interface a2l_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/annexb_to_length_prefixed_nal_top.sv -----
// Channel  | Dir | Payload     | Meaning
// i_req    | in  | t_in_item   | one Annex B byte per request, last_byte ends the buffer
// o_res    | out | t_out_item  | payload write, length header write or done record
//
// A request is taken when the result buffer is empty or its final result leaves in
// that cycle; its results (zero to nine) are built at once into a thirteen-slot result
// buffer and leave one per cycle while o_res is ready, the first offered in the cycle
// after the request. A request that makes at most one result therefore sustains one per
// cycle while o_res is ready; one that makes more holds the input until the single output
// port drains the buffer. Reset is synchronous, active low, and clears the scan state
// and the result buffer. Output stalls hold the input while any result waits.
`include "annexb_to_length_prefixed_nal_top_macros.svh"

module annexb_to_length_prefixed_nal_top
    import a2l_pkg::*;
#(
    parameter int unsigned OUT_ADDR_BITS = A2L_OUT_ADDR_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    a2l_chan_if.sink    i_req,
    a2l_chan_if.source  o_res
);

    localparam int unsigned AW = OUT_ADDR_BITS;
    localparam int unsigned PW = AW + 1;          // pointer, can hold the capacity
    localparam int unsigned HW = AW + 2;          // header address plus offset
    localparam logic [PW-1:0] CAP = {1'b1, {AW{1'b0}}};
    localparam int unsigned NSLOT = 13;
    localparam int unsigned IW = $clog2(NSLOT);
    localparam int unsigned SLOT_HDR1 = 4;
    localparam int unsigned SLOT_HDR2 = 8;
    localparam int unsigned SLOT_DONE = 12;

    typedef struct packed {
        logic [3:0]       vld;
        logic [3:0]       ovf;
        logic [3:0][15:0] addr;
        logic [3:0][7:0]  data;
        logic             ovf_out;
    } t_close;

    typedef struct packed {
        logic          vld;
        logic          ovf_at;
        logic [15:0]   addr;
        logic [PW-1:0] wp;
        logic          ovf;
    } t_pay;

    // Closing a unit writes its big-endian length into the reserved slot.
    function automatic t_close f_close(input logic is_open, input logic [PW-1:0] hdr,
                                       input logic [PW-1:0] wp, input logic ovf);
        t_close        c;
        logic [HW-1:0] hdr_end;
        logic [HW-1:0] len;
        logic [31:0]   len32;
        logic [HW-1:0] a;
        logic          o;
        c       = '0;
        o       = ovf;
        hdr_end = HW'(hdr) + HW'(4);
        len     = (HW'(wp) >= hdr_end) ? (HW'(wp) - hdr_end) : '0;
        len32   = 32'(len);
        for (int k = 0; k < 4; k++) begin
            a         = HW'(hdr) + HW'(k);
            c.addr[k] = 16'(a);
            c.data[k] = len32[8*(3-k) +: 8];
            c.ovf[k]  = o;
            if (is_open) begin
                if (a[HW-1:AW] != '0) begin
                    o = 1'b1;
                end else begin
                    c.vld[k] = 1'b1;
                end
            end
        end
        c.ovf_out = o;
        return c;
    endfunction

    function automatic t_pay f_pay(input logic en, input logic [PW-1:0] wp,
                                   input logic ovf);
        t_pay p;
        p.vld    = 1'b0;
        p.ovf_at = ovf;
        p.addr   = 16'(wp);
        p.wp     = wp;
        p.ovf    = ovf;
        if (en) begin
            if (wp[AW]) begin
                p.ovf = 1'b1;
            end else begin
                p.vld = 1'b1;
                p.wp  = wp + PW'(1);
            end
        end
        return p;
    endfunction

    // Scan state.
    logic [23:0]   r_win,  n_win;
    logic [1:0]    r_fill, n_fill;
    logic          r_open, n_open;
    logic [PW-1:0] r_hdr,  n_hdr;
    logic [PW-1:0] r_wp,   n_wp;
    logic          r_ovf,  n_ovf;

    // Result buffer.
    logic [NSLOT-1:0] r_mask, n_mask;
    logic [15:0]      r_saddr [NSLOT];
    logic [15:0]      n_saddr [NSLOT];
    logic [7:0]       r_sdata [NSLOT];
    logic [7:0]       n_sdata [NSLOT];
    logic             r_sovf  [NSLOT];
    logic             n_sovf  [NSLOT];
    logic [16:0]      r_total, n_total;

    logic          in_fire, out_fire;
    logic [7:0]    in_byte;
    logic          in_last;
    logic          start_code;
    logic          pre_pay;
    logic [23:0]   shift_win;
    logic [1:0]    shift_fill;
    logic          scan_open;
    t_pay          pay0, pay1, pay2, pay3;
    t_close        cl1, cl2;
    logic [HW-1:0] open_sum;
    logic [PW-1:0] open_wp;
    logic          m_open;
    logic [PW-1:0] m_hdr, m_wp;
    logic          m_ovf;

    logic [NSLOT-1:0] sel;
    logic [IW-1:0]    sel_idx;
    t_out_item        out_item;

    assign in_fire  = i_req.valid && i_req.ready;
    assign out_fire = o_res.valid && o_res.ready;
    assign in_byte  = i_req.data.data_byte;
    assign in_last  = i_req.data.last_byte;

    // A request may enter when the buffer is empty or its final result leaves now.
    assign i_req.ready = (r_mask == '0)
                      || (((r_mask & (r_mask - NSLOT'(1))) == '0) && o_res.ready);

    always_comb begin
        start_code = (r_fill == 2'd3) && (r_win == 24'd0) && (in_byte == 8'h01);
        pre_pay    = (r_fill == 2'd3);
        shift_win  = {r_win[15:0], in_byte};
        shift_fill = pre_pay ? 2'd3 : (r_fill + 2'd1);
        scan_open  = r_open && !start_code;

        // Oldest window byte leaves, then the flush at the buffer end.
        pay0 = f_pay(scan_open && pre_pay, r_wp, r_ovf);
        pay1 = f_pay(scan_open && in_last && (shift_fill == 2'd3), pay0.wp, pay0.ovf);
        pay2 = f_pay(scan_open && in_last && (shift_fill >= 2'd2), pay1.wp, pay1.ovf);
        pay3 = f_pay(scan_open && in_last, pay2.wp, pay2.ovf);

        // A start code closes the open unit and reserves a new header slot.
        cl1      = f_close(r_open && start_code, r_hdr, pay3.wp, pay3.ovf);
        open_sum = HW'(r_wp) + HW'(4);
        open_wp  = (open_sum > HW'(CAP)) ? CAP : PW'(open_sum);
        m_open   = start_code ? 1'b1 : r_open;
        m_hdr    = start_code ? r_wp : r_hdr;
        m_wp     = start_code ? open_wp : pay3.wp;
        m_ovf    = cl1.ovf_out;

        cl2 = f_close(m_open && in_last, m_hdr, m_wp, m_ovf);

        n_mask = '0;
        n_mask[0] = pay0.vld;
        n_mask[1] = pay1.vld;
        n_mask[2] = pay2.vld;
        n_mask[3] = pay3.vld;
        n_mask[SLOT_HDR1 +: 4] = cl1.vld;
        n_mask[SLOT_HDR2 +: 4] = cl2.vld;
        n_mask[SLOT_DONE] = in_last;

        n_saddr[0] = pay0.addr;   n_sdata[0] = r_win[23:16];    n_sovf[0] = pay0.ovf_at;
        n_saddr[1] = pay1.addr;   n_sdata[1] = shift_win[23:16]; n_sovf[1] = pay1.ovf_at;
        n_saddr[2] = pay2.addr;   n_sdata[2] = shift_win[15:8];  n_sovf[2] = pay2.ovf_at;
        n_saddr[3] = pay3.addr;   n_sdata[3] = shift_win[7:0];   n_sovf[3] = pay3.ovf_at;
        for (int k = 0; k < 4; k++) begin
            n_saddr[SLOT_HDR1 + k] = cl1.addr[k];
            n_sdata[SLOT_HDR1 + k] = cl1.data[k];
            n_sovf[SLOT_HDR1 + k]  = cl1.ovf[k];
            n_saddr[SLOT_HDR2 + k] = cl2.addr[k];
            n_sdata[SLOT_HDR2 + k] = cl2.data[k];
            n_sovf[SLOT_HDR2 + k]  = cl2.ovf[k];
        end
        n_saddr[SLOT_DONE] = 16'd0;
        n_sdata[SLOT_DONE] = 8'd0;
        n_sovf[SLOT_DONE]  = cl2.ovf_out;
        n_total            = 17'(m_wp);

        // The buffer end returns the scan state to its reset values.
        if (in_last) begin
            n_win  = '0;
            n_fill = '0;
            n_open = 1'b0;
            n_hdr  = '0;
            n_wp   = '0;
            n_ovf  = 1'b0;
        end else begin
            n_win  = start_code ? 24'd0 : shift_win;
            n_fill = start_code ? 2'd0 : shift_fill;
            n_open = m_open;
            n_hdr  = m_hdr;
            n_wp   = m_wp;
            n_ovf  = m_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_fill <= '0;
            r_open <= 1'b0;
            r_hdr  <= '0;
            r_wp   <= '0;
            r_ovf  <= 1'b0;
            r_mask <= '0;
        end else begin
            if (in_fire) begin
                r_win  <= n_win;
                r_fill <= n_fill;
                r_open <= n_open;
                r_hdr  <= n_hdr;
                r_wp   <= n_wp;
                r_ovf  <= n_ovf;
                r_mask <= n_mask;
            end else if (out_fire) begin
                r_mask <= r_mask & ~sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_saddr <= n_saddr;
            r_sdata <= n_sdata;
            r_sovf  <= n_sovf;
            r_total <= n_total;
        end
    end

    // Results leave lowest slot first.
    assign sel = r_mask & (~r_mask + NSLOT'(1));

    always_comb begin
        sel_idx = '0;
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                sel_idx = IW'(i);
            end
        end
    end

    always_comb begin
        if (sel_idx < IW'(SLOT_HDR1)) begin
            out_item.kind = KIND_PAYLOAD;
        end else if (sel_idx < IW'(SLOT_DONE)) begin
            out_item.kind = KIND_HEADER;
        end else begin
            out_item.kind = KIND_DONE;
        end
        out_item.write_addr  = r_saddr[sel_idx];
        out_item.write_data  = r_sdata[sel_idx];
        out_item.total_size  = (sel_idx == IW'(SLOT_DONE)) ? r_total : 17'd0;
        out_item.overflow    = r_sovf[sel_idx];
        out_item.last_of_run = ((r_mask & ~sel) == '0);
    end

    assign o_res.valid = (r_mask != '0);
    assign o_res.data  = out_item;

    `A2L_ASSERT_NEXT(a_state_clear_after_last, i_clk, i_rst_n, in_fire && in_last, (r_wp == '0) && !r_open && (r_fill == 2'd0) && !r_ovf, "scan state not cleared after buffer end")
    `A2L_ASSERT_IMPLIES(a_done_is_last, i_clk, i_rst_n, o_res.valid && (o_res.data.kind == KIND_DONE), o_res.data.last_of_run, "done record not marked last")
    `A2L_ASSERT_IMPLIES(a_pointer_bounds, i_clk, i_rst_n, r_open, (r_wp >= r_hdr) && (r_wp <= CAP), "write pointer outside unit or capacity")

endmodule
